// ----- sv/ppu_pkg.sv -----
// Shared constants and types for the polyphase 4x4 upscaler.
`default_nettype none
package ppu_pkg;
  localparam int TAPS          = 4;
  localparam int ROWS          = 4;
  localparam int MAX_SCALE_DEF = 4;
  localparam int PIX_W         = 8;
  localparam int COEF_W        = 16;
  localparam int CIDX_W        = 6;
  localparam int CFG_W         = 3;
  localparam int ACC_W         = 29;
  localparam int SUM_W         = 21;
  localparam int QUO_W         = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int COEF_PER_PH   = 16;
  localparam int PROD_W        = PIX_W + 1 + COEF_W;

  localparam logic [CFG_W-1:0] SCALE_RESET = 3'd2;
  localparam logic [QUO_W-1:0] PIX_MAX     = 8'd255;

  localparam logic CMD_COEF   = 1'b0;
  localparam logic CMD_COLUMN = 1'b1;

  // four columns x-1 .. x+2, each with row -1 in the low byte
  typedef logic [TAPS-1:0][ROWS*PIX_W-1:0] ppu_win_t;

  // one output position waiting for the back end
  typedef struct packed {
    ppu_win_t win;
    logic     run_last;
    logic     row_end;
  } ppu_job_t;

  // coefficient write from the front end
  typedef struct packed {
    logic              we;
    logic [COEF_W-1:0] data;
  } ppu_cwr_t;
endpackage
`default_nettype wire

// ----- sv/ppu_in_if.sv -----
// Input channel: coefficient and column items.
`default_nettype none
interface ppu_in_if import ppu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [CIDX_W-1:0]        coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic [PIX_W-1:0]         pixel_row_a;
  logic [PIX_W-1:0]         pixel_row_b;
  logic [PIX_W-1:0]         pixel_row_c;
  logic [PIX_W-1:0]         pixel_row_d;
  logic                     last_column;

  modport source (output valid, cmd, coef_index, coef_value, pixel_row_a, pixel_row_b,
                  pixel_row_c, pixel_row_d, last_column, input ready);
  modport sink   (input valid, cmd, coef_index, coef_value, pixel_row_a, pixel_row_b,
                  pixel_row_c, pixel_row_d, last_column, output ready);
endinterface
`default_nettype wire

// ----- sv/ppu_out_if.sv -----
// Result channel: upscaled pixels.
`default_nettype none
interface ppu_out_if import ppu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             run_last;
  logic             row_end;
  logic             zero_weight_sum;

  modport source (output valid, out_pixel, run_last, row_end, zero_weight_sum, input ready);
  modport sink   (input valid, out_pixel, run_last, row_end, zero_weight_sum, output ready);
endinterface
`default_nettype wire

// ----- sv/ppu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ----- sv/ppu_front.sv -----
// Front end: takes items, writes coefficients, keeps the column window, queues positions.
`default_nettype none
module ppu_front import ppu_pkg::*; #(
  parameter int MAX_SCALE = MAX_SCALE_DEF,
  localparam int TDEPTH = COEF_PER_PH * MAX_SCALE,
  localparam int TAW = $clog2(TDEPTH)
) (
  input  logic           clk,
  input  logic           rst_n,
  ppu_in_if.sink         in_ch,
  input  logic           back_idle,
  output ppu_cwr_t       cwr,
  output logic [TAW-1:0] cwr_addr,
  output ppu_job_t       push_job,
  output logic           push_valid,
  input  logic           push_ready
);
  typedef enum logic {F_IDLE, F_GEN} fstate_t;

  fstate_t                 state_r, state_nxt;
  ppu_win_t                win_r, win_nxt;
  logic [1:0]              seen_r, seen_nxt;
  logic [ROWS*PIX_W-1:0]   col_r, col_nxt;
  logic [1:0]              k_r, k_nxt;
  logic [1:0]              first_k_r, first_k_nxt;

  logic [ROWS*PIX_W-1:0]   col;
  ppu_win_t                win_in;
  logic                    accept;
  logic                    emit;

  function automatic ppu_win_t shift_in(ppu_win_t w, logic [ROWS*PIX_W-1:0] c);
    shift_in = {c, w[3], w[2], w[1]};
  endfunction

  // coefficient slot modulo the table depth; index stays below 64
  function automatic logic [TAW-1:0] slot_mod(logic [CIDX_W-1:0] idx);
    logic [CIDX_W:0] v;
    v = {1'b0, idx};
    for (int i = 0; i < 4; i++) begin
      if (v >= (CIDX_W+1)'(TDEPTH)) begin
        v = v - (CIDX_W+1)'(TDEPTH);
      end
    end
    slot_mod = TAW'(v);
  endfunction

  assign col    = {in_ch.pixel_row_d, in_ch.pixel_row_c, in_ch.pixel_row_b, in_ch.pixel_row_a};
  assign win_in = (seen_r == 2'd0) ? {TAPS{col}} : shift_in(win_r, col);

  // coefficient items wait until everything before them has been computed
  always_comb begin
    in_ch.ready = 1'b0;
    if (state_r == F_IDLE) begin
      in_ch.ready = (in_ch.cmd == CMD_COEF) ? back_idle : push_ready;
    end
  end
  assign accept = in_ch.valid && in_ch.ready;

  assign cwr.we   = accept && (in_ch.cmd == CMD_COEF);
  assign cwr.data = in_ch.coef_value;
  assign cwr_addr = slot_mod(in_ch.coef_index);

  assign emit = (k_r >= first_k_r);

  // window update and position generation
  always_comb begin
    state_nxt   = state_r;
    win_nxt     = win_r;
    seen_nxt    = seen_r;
    col_nxt     = col_r;
    k_nxt       = k_r;
    first_k_nxt = first_k_r;
    push_valid  = 1'b0;
    push_job    = '{win: win_in, run_last: 1'b1, row_end: 1'b0};
    unique case (state_r)
      F_IDLE: begin
        if (accept && in_ch.cmd == CMD_COLUMN) begin
          win_nxt = win_in;
          if (!in_ch.last_column) begin
            push_valid = (seen_r >= 2'd2);
            if (seen_r != 2'd3) begin
              seen_nxt = seen_r + 2'd1;
            end
          end else begin
            state_nxt   = F_GEN;
            col_nxt     = col;
            k_nxt       = 2'd0;
            first_k_nxt = (seen_r >= 2'd2) ? 2'd0 : 2'd2 - seen_r;
          end
        end
      end
      F_GEN: begin
        push_valid = emit;
        push_job   = '{win: win_r, run_last: (k_r == 2'd2), row_end: (k_r == 2'd2)};
        if (!emit || push_ready) begin
          if (k_r == 2'd2) begin
            state_nxt = F_IDLE;
            seen_nxt  = 2'd0;
          end else begin
            win_nxt = shift_in(win_r, col_r);
            k_nxt   = k_r + 2'd1;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      seen_r  <= 2'd0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      win_r   <= win_nxt;
    end
    col_r     <= col_nxt;
    k_r       <= k_nxt;
    first_k_r <= first_k_nxt;
  end
endmodule
`default_nettype wire

// ----- sv/ppu_queue.sv -----
// Two-entry queue of output positions between front and back end.
`default_nettype none
module ppu_queue import ppu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ppu_job_t push_job,
  input  logic     push_valid,
  output logic     push_ready,
  output ppu_job_t pop_job,
  output logic     pop_valid,
  input  logic     pop
);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  ppu_job_t      ent_r [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QW:0]   count_r;
  logic          do_push, do_pop;

  function automatic logic [QW-1:0] ptr_inc(logic [QW-1:0] p);
    ptr_inc = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  assign push_ready = (count_r != (QW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      count_r <= count_r + (QW+1)'(do_push) - (QW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

// ----- sv/ppu_back.sv -----
// Back end: 16-tap multiply-accumulate per phase, serial divide, clamp, output register.
`default_nettype none
module ppu_back import ppu_pkg::*; #(
  parameter int MAX_SCALE = MAX_SCALE_DEF,
  localparam int TAW = $clog2(COEF_PER_PH * MAX_SCALE),
  localparam int PW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [CFG_W-1:0]         scale,
  input  ppu_job_t                 pop_job,
  input  logic                     pop_valid,
  output logic                     pop,
  output logic [TAW-1:0]           rd_addr,
  input  logic signed [COEF_W-1:0] rd_data,
  output logic                     busy,
  ppu_out_if.source                out_ch
);
  typedef enum logic [2:0] {B_IDLE, B_MAC, B_DSET, B_DIV, B_DONE} bstate_t;

  bstate_t                  state_r, state_nxt;
  ppu_job_t                 job_r, job_nxt;
  logic [PW-1:0]            p_r, p_nxt;
  logic [4:0]               cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [ACC_W-1:0]         rem_r, rem_nxt;
  logic [SUM_W-1:0]         dvs_r, dvs_nxt;
  logic [QUO_W-1:0]         q_r, q_nxt;
  logic [2:0]               bit_r, bit_nxt;
  logic                     zero_r, zero_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]         out_pix_r, out_pix_nxt;
  logic                     out_rl_r, out_rl_nxt;
  logic                     out_re_r, out_re_nxt;
  logic                     out_zero_r, out_zero_nxt;

  logic [3:0]               nphase;
  logic                     last_phase;
  logic [3:0]               tap;
  logic [PIX_W-1:0]         pix;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         mag_a, mag_b, trial;
  logic                     a_neg, s_neg;
  logic                     out_free;

  // phases in use: zero acts as one, above the maximum saturates
  always_comb begin
    if (scale == '0) begin
      nphase = 4'd1;
    end else if (4'(scale) > 4'(MAX_SCALE)) begin
      nphase = 4'(MAX_SCALE);
    end else begin
      nphase = 4'(scale);
    end
  end
  assign last_phase = ((4'(p_r) + 4'd1) == nphase);

  // tap address issued in the cycle before its accumulate
  assign rd_addr = TAW'({p_r, cnt_r[3:0]});
  assign tap     = cnt_r[3:0] - 4'd1;
  assign pix     = job_r.win[tap[1:0]][{tap[3:2], 3'b000} +: PIX_W];
  assign prod    = $signed({1'b0, pix}) * rd_data;

  // magnitudes for the divider
  assign a_neg = acc_r[ACC_W-1];
  assign s_neg = sum_r[SUM_W-1];
  assign mag_a = a_neg ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign mag_b = s_neg ? ACC_W'(-ACC_W'(sum_r)) : ACC_W'(sum_r);
  assign trial = ACC_W'(dvs_r) << bit_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign busy     = (state_r != B_IDLE);
  assign pop      = (state_r == B_IDLE) && pop_valid;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pix_nxt   = out_pix_r;
    out_rl_nxt    = out_rl_r;
    out_re_nxt    = out_re_r;
    out_zero_nxt  = out_zero_r;
    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          job_nxt   = pop_job;
          p_nxt     = '0;
          cnt_nxt   = '0;
          acc_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = B_MAC;
        end
      end
      B_MAC: begin
        if (cnt_r != 5'd0) begin
          acc_nxt = acc_r + ACC_W'(prod);
          sum_nxt = sum_r + SUM_W'(rd_data);
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd16) begin
          state_nxt = B_DSET;
        end
      end
      B_DSET: begin
        zero_nxt = 1'b0;
        q_nxt    = '0;
        rem_nxt  = mag_a;
        dvs_nxt  = SUM_W'(mag_b);
        bit_nxt  = 3'd7;
        if (sum_r == '0) begin
          zero_nxt  = 1'b1;
          state_nxt = B_DONE;
        end else if (acc_r == '0 || a_neg != s_neg) begin
          state_nxt = B_DONE;
        end else if (mag_a >= (mag_b << QUO_W)) begin
          q_nxt     = PIX_MAX;
          state_nxt = B_DONE;
        end else begin
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        // one quotient bit per cycle, restoring
        if (rem_r >= trial) begin
          rem_nxt        = rem_r - trial;
          q_nxt[bit_r]   = 1'b1;
        end
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = q_r;
          out_zero_nxt  = zero_r;
          out_rl_nxt    = job_r.run_last && last_phase;
          out_re_nxt    = job_r.row_end && last_phase;
          if (last_phase) begin
            state_nxt = B_IDLE;
          end else begin
            p_nxt     = p_r + PW'(1);
            cnt_nxt   = '0;
            acc_nxt   = '0;
            sum_nxt   = '0;
            state_nxt = B_MAC;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    p_r        <= p_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    sum_r      <= sum_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    q_r        <= q_nxt;
    bit_r      <= bit_nxt;
    zero_r     <= zero_nxt;
    out_pix_r  <= out_pix_nxt;
    out_rl_r   <= out_rl_nxt;
    out_re_r   <= out_re_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_pixel       = out_pix_r;
  assign out_ch.run_last        = out_rl_r;
  assign out_ch.row_end         = out_re_r;
  assign out_ch.zero_weight_sum = out_zero_r;
endmodule
`default_nettype wire

// ----- sv/polyphase_4x4_upscaler_top.sv -----
// Top level of the polyphase 4x4 upscaler.
//
//   port      dir   flow        carries
//   in_ch     in    valid/ready coefficient writes and pixel columns
//   out_ch    out   valid/ready upscaled pixels with run_last/row_end/zero flags
//   cfg_*     in    write only  upscale ratio (phases per column)
//
// Each output pixel passes through the back end in steps: the 16-tap
// multiply-accumulate through the coefficient RAM read port, a setup step, the
// serial divider for the 8-bit quotient (skipped for a zero, negative or
// clamped result) and a hand-off step. A position leaves the queue and is
// then run once per phase of the ratio; a last column yields up to three
// positions. Reset is synchronous and active low; no clearing pass is needed.
// A two-entry position queue and the output register let each side stall alone;
// a coefficient item waits until all earlier positions are computed.
`default_nettype none
module polyphase_4x4_upscaler_top import ppu_pkg::*; #(
  parameter int MAX_SCALE = MAX_SCALE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ppu_in_if.sink           in_ch,
  ppu_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);
  localparam int TDEPTH = COEF_PER_PH * MAX_SCALE;
  localparam int TAW = $clog2(TDEPTH);

  logic [CFG_W-1:0]         scale_r;
  ppu_cwr_t                 cwr;
  logic [TAW-1:0]           cwr_addr;
  logic [TAW-1:0]           rd_addr;
  logic [COEF_W-1:0]        rd_raw;
  ppu_job_t                 push_job, pop_job;
  logic                     push_valid, push_ready, pop_valid, pop, back_busy;

  // scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_data;
    end
  end

  ppu_front #(.MAX_SCALE(MAX_SCALE)) u_front (
    .clk, .rst_n, .in_ch,
    .back_idle  (!back_busy && !pop_valid),
    .cwr, .cwr_addr, .push_job, .push_valid, .push_ready
  );

  ppu_queue u_queue (
    .clk, .rst_n, .push_job, .push_valid, .push_ready, .pop_job, .pop_valid, .pop
  );

  ppu_ram #(.WIDTH(COEF_W), .DEPTH(TDEPTH)) u_coef_ram (
    .clk,
    .we    (cwr.we),
    .waddr (cwr_addr),
    .wdata (cwr.data),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  ppu_back #(.MAX_SCALE(MAX_SCALE)) u_back (
    .clk, .rst_n,
    .scale   (scale_r),
    .pop_job, .pop_valid, .pop, .rd_addr,
    .rd_data ($signed(rd_raw)),
    .busy    (back_busy),
    .out_ch
  );
endmodule
`default_nettype wire
